// ===== hw/rtl/lfu_pkg.sv =====
`default_nettype none

package lfu_pkg;

    // Geometry
    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W    = $clog2(ENTRIES + 1);
    localparam int CAP_BITS = 5;
    localparam int CAP_W    = (CAP_BITS > OCC_W) ? CAP_BITS : OCC_W;

    // Register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

    // Request modes
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic [31:0]        count;
        logic [63:0]        stamp;
    } t_entry;

    typedef struct packed {
        logic [CAP_BITS-1:0] capacity;
        logic                clear;
    } t_cfg;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ===== hw/rtl/lfu_ram.sv =====
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word through a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_apb.sv =====
`default_nettype none

module lfu_apb
    import lfu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [CAP_BITS-1:0] r_capacity;
    logic                r_clear;
    logic                wr_cap;

    assign pready = 1'b1;
    assign wr_cap = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_CAPACITY);

    // Hold capacity; pulse a clear on every capacity write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
            r_clear    <= 1'b0;
        end else begin
            r_clear <= wr_cap;
            if (wr_cap) begin
                r_capacity <= pwdata[CAP_BITS-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_CAPACITY) begin
            prdata = DATA_W'(r_capacity);
        end
    end

    assign o_cfg.capacity = r_capacity;
    assign o_cfg.clear    = r_clear;

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_cache_controller.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_in_req  (mode, lookup_key, write_value)
// response  out        o_out_valid / i_out_stall o_out_rsp (hit, read_value, evicted, evicted_key)
// config    in         psel/penable/pwrite       capacity at byte address 0
//
// A request is accepted, then the scan walks the entry memory at one read per
// cycle, visiting every entry in turn, and then the result is written back.
// Requests are handled one at a time; o_in_stall is high from accept to write-back.
// The response sits in an output register; a stalled response holds only the
// write-back of the following request. Reset empties the cache.

module lfu_cache_controller
    import lfu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_req              i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_rsp                   o_out_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    t_cfg cfg;

    logic [1:0]         r_state;
    logic [IDX_W-1:0]   r_idx;
    t_req               r_req;
    logic               r_found;
    logic [IDX_W-1:0]   r_found_idx;
    t_entry             r_found_ent;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_min_found;
    logic [IDX_W-1:0]   r_min_idx;
    t_entry             r_min_ent;
    logic [ENTRIES-1:0] r_valid;
    logic [OCC_W-1:0]   r_occ;
    logic [63:0]        r_stamp_ctr;
    logic               r_out_valid;
    t_rsp               r_out_rsp;

    logic             accept;
    logic             out_free;
    logic             last;
    logic             cur_valid;
    logic [IDX_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_word;
    t_entry           rd_ent;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_entry           wr_ent;
    logic [CAP_W-1:0] cap_ext;
    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W-1:0] occ_ext;
    logic             full;

    lfu_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_ent),
        .i_raddr (rd_addr),
        .o_rdata (rd_word)
    );

    assign rd_ent     = t_entry'(rd_word);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last       = (r_idx == IDX_W'(ENTRIES - 1));
    assign cur_valid  = r_valid[r_idx];

    // Walk the entry memory; the read for entry 0 goes out at accept
    assign rd_addr = (r_state == S_IDLE) ? '0 : r_idx + IDX_W'(1);

    // Effective capacity saturates at the number of entries
    assign cap_ext = CAP_W'(cfg.capacity);
    assign cap_eff = (cap_ext > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : cap_ext;
    assign occ_ext = CAP_W'(r_occ);
    assign full    = (occ_ext >= cap_eff);

    // Decide the write-back and the response
    logic         do_write;
    logic         n_alloc;
    logic         n_bump;
    logic [IDX_W-1:0] n_slot;
    t_rsp         n_rsp;

    always_comb begin
        do_write = 1'b0;
        n_alloc  = 1'b0;
        n_bump   = 1'b0;
        n_slot   = r_found_idx;
        n_rsp    = '0;
        wr_ent   = r_found_ent;
        if (cfg.capacity != '0) begin
            if (r_found) begin
                do_write = 1'b1;
                n_rsp.hit = 1'b1;
                if (r_req.mode == MODE_GET) begin
                    n_rsp.read_value = r_found_ent.value;
                end else begin
                    wr_ent.value = r_req.write_value;
                end
                if (r_found_ent.count != COUNT_MAX) begin
                    wr_ent.count = r_found_ent.count + 32'd1;
                    wr_ent.stamp = r_stamp_ctr;
                    n_bump       = 1'b1;
                end
            end else if (r_req.mode == MODE_SET) begin
                wr_ent.key   = r_req.lookup_key;
                wr_ent.value = r_req.write_value;
                wr_ent.count = 32'd1;
                wr_ent.stamp = r_stamp_ctr;
                if (full && r_min_found) begin
                    do_write          = 1'b1;
                    n_bump            = 1'b1;
                    n_slot            = r_min_idx;
                    n_rsp.evicted     = 1'b1;
                    n_rsp.evicted_key = r_min_ent.key;
                end else if (r_free_found) begin
                    do_write = 1'b1;
                    n_bump   = 1'b1;
                    n_alloc  = 1'b1;
                    n_slot   = r_free_idx;
                end
            end
        end
    end

    assign we    = (r_state == S_WRITE) && out_free && do_write;
    assign waddr = n_slot;

    // Sequencer and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_occ       <= '0;
            r_stamp_ctr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop an accepted response unless the write-back replaces it
            if (r_out_valid && !i_out_stall && (r_state != S_WRITE)) begin
                r_out_valid <= 1'b0;
            end
            if (cfg.clear) begin
                r_valid <= '0;
                r_occ   <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                        r_idx   <= '0;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (last) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (do_write) begin
                            r_valid[n_slot] <= 1'b1;
                        end
                        if (n_alloc) begin
                            r_occ <= r_occ + OCC_W'(1);
                        end
                        if (n_bump) begin
                            r_stamp_ctr <= r_stamp_ctr + 64'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload: request, scan results, response
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req        <= i_in_req;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_min_found  <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (cur_valid && !r_found && (rd_ent.key == r_req.lookup_key)) begin
                r_found     <= 1'b1;
                r_found_idx <= r_idx;
                r_found_ent <= rd_ent;
            end
            if (!cur_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_idx;
            end
            if (cur_valid && (!r_min_found ||
                    ({rd_ent.count, rd_ent.stamp} < {r_min_ent.count, r_min_ent.stamp}))) begin
                r_min_found <= 1'b1;
                r_min_idx   <= r_idx;
                r_min_ent   <= rd_ent;
            end
        end
        if ((r_state == S_WRITE) && out_free) begin
            r_out_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_checker.sv =====
`default_nettype none

module lfu_checker
    import lfu_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_rsp o_out_rsp
);

    // Hold a stalled response
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled response changed");

    // No response survives reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    // Evicted key only with an eviction
    a_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_rsp.evicted |-> o_out_rsp.evicted_key == 0)
        else $error("evicted key without eviction");

    // Read data only on a hit
    a_read_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_rsp.read_value != 0) |-> o_out_rsp.hit)
        else $error("read value without hit");

    // A hit never evicts
    a_hit_noevict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.evicted |-> !o_out_rsp.hit)
        else $error("eviction on a hit");

endmodule

bind lfu_cache_controller lfu_checker u_lfu_checker (.*);

`default_nettype wire

// ===== verif/lfu_cache_checker.sv =====
module lfu_cache_checker
    import lfu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire t_req              in_req,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire t_rsp              out_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic [DATA_W-1:0] prdata,
    input  wire logic              pready,
    output int                     mismatches,
    output int                     outstanding,
    output int                     responses,
    output int                     hit_total,
    output int                     evict_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));

    // Shadow copy of the cache contents and its register
    bit [CAP_BITS-1:0] capacity;
    bit                slot_valid [ENTRIES];
    bit [31:0]         slot_key   [ENTRIES];
    bit [31:0]         slot_value [ENTRIES];
    bit [31:0]         slot_count [ENTRIES];
    bit [63:0]         slot_stamp [ENTRIES];
    bit [63:0]         stamp_next;
    int                fill;
    t_rsp              predicted_rsp_q[$];
    int                err_n;
    int                rsp_n;
    int                hit_n;
    int                evict_n;

    function automatic void empty_cache();
        for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
        fill = 0;
    endfunction

    // Raise the use count and restamp, unless the count is pinned at its maximum
    function automatic void bump_use(int slot);
        if (slot_count[slot] != COUNT_MAX) begin
            slot_count[slot] = slot_count[slot] + 32'd1;
            slot_stamp[slot] = stamp_next;
            stamp_next       = stamp_next + 64'd1;
        end
    endfunction

    // Apply one request to the shadow cache and return the response it must produce
    function automatic t_rsp lookup_and_update(t_req req);
        t_rsp rsp;
        int   eff_cap;
        int   found;
        int   slot;
        rsp     = '0;
        eff_cap = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
        found   = -1;
        slot    = -1;
        if (eff_cap == 0) return rsp;

        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && slot_valid[i] && slot_key[i] == req.lookup_key) found = i;
        end

        if (found >= 0) begin
            rsp.hit = 1'b1;
            if (req.mode == MODE_GET) rsp.read_value = slot_value[found];
            else slot_value[found] = req.write_value;
            bump_use(found);
            return rsp;
        end
        if (req.mode == MODE_GET) return rsp;

        // Full: pick lowest count, earliest stamp, lowest index
        if (fill >= eff_cap) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_valid[i] && (slot < 0 || slot_count[i] < slot_count[slot] ||
                    (slot_count[i] == slot_count[slot] &&
                     slot_stamp[i] < slot_stamp[slot])))
                    slot = i;
            end
            if (slot >= 0) begin
                rsp.evicted     = 1'b1;
                rsp.evicted_key = slot_key[slot];
            end
        end
        if (slot < 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && !slot_valid[i]) slot = i;
            end
            if (slot < 0) return rsp;
            fill++;
        end
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = req.lookup_key;
        slot_value[slot] = req.write_value;
        slot_count[slot] = 32'd1;
        slot_stamp[slot] = stamp_next;
        stamp_next       = stamp_next + 64'd1;
        return rsp;
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_n++;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            capacity   = CAPACITY_RESET;
            stamp_next = '0;
            empty_cache();
            predicted_rsp_q.delete();
        end else begin
            // Check responses before taking the request of the same edge
            if (out_valid && !out_stall) begin
                if (predicted_rsp_q.size() == 0) begin
                    $error("response with no request waiting: hit %0b read %0d",
                           out_rsp.hit, out_rsp.read_value);
                    err_n++;
                end else begin
                    t_rsp want;
                    want = predicted_rsp_q.pop_front();
                    compare_field("hit", 32'(want.hit), 32'(out_rsp.hit));
                    compare_field("read_value", want.read_value, out_rsp.read_value);
                    compare_field("evicted", 32'(want.evicted), 32'(out_rsp.evicted));
                    compare_field("evicted_key", want.evicted_key, out_rsp.evicted_key);
                    rsp_n++;
                    if (want.hit) hit_n++;
                    if (want.evicted) evict_n++;
                end
            end

            // Track register writes and check readback
            if (psel && penable && pready && paddr == CAP_ADDR) begin
                if (pwrite) begin
                    capacity = pwdata[CAP_BITS-1:0];
                    empty_cache();
                end else begin
                    compare_field("capacity", DATA_W'(capacity), prdata);
                end
            end

            if (in_valid && !in_stall) predicted_rsp_q.push_back(lookup_and_update(in_req));
        end

        mismatches  <= err_n;
        outstanding <= predicted_rsp_q.size();
        responses   <= rsp_n;
        hit_total   <= hit_n;
        evict_total <= evict_n;
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_req              i_in_req;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_rsp              o_out_rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int mismatches;
    int outstanding;
    int responses;
    int hit_total;
    int evict_total;
    int settings_run;
    int stall_left;
    bit quiet_in;
    bit quiet_out;

    lfu_cache_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lfu_cache_checker u_checker (
        .clk         (i_clk),
        .rst_n       (i_rst_n),
        .in_valid    (i_in_valid),
        .in_stall    (o_in_stall),
        .in_req      (i_in_req),
        .out_valid   (o_out_valid),
        .out_stall   (i_out_stall),
        .out_rsp     (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .responses   (responses),
        .hit_total   (hit_total),
        .evict_total (evict_total)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Hold off the response side a random number of valid cycles after each response
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (o_out_valid && !i_out_stall) begin
            stall_left = quiet_out ? 0 : $urandom_range(0, 12);
            i_out_stall <= (stall_left != 0);
        end else if (o_out_valid && stall_left != 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end
    end

    task automatic send_request(input logic op, input logic [31:0] key,
                                input logic [31:0] value);
        int gap;
        i_in_valid <= 1'b1;
        i_in_req   <= '{mode: op, lookup_key: key, write_value: value};
        do @(posedge i_clk); while (o_in_stall);
        gap = quiet_in ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every response, then let the write-back finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    // Write the capacity register on an idle cache, then read it back
    task automatic write_capacity(input int value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        settings_run++;
    endtask

    // Mostly keys from a small pool so hits and evictions are frequent
    task automatic run_random(input int count, input int pool_size);
        logic [31:0] pool [24];
        logic [31:0] key;
        logic        op;
        for (int i = 0; i < 24; i++) pool[i] = $urandom;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                quiet_in = ($urandom_range(0, 3) == 0);
                quiet_out <= ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else key = pool[$urandom_range(0, pool_size - 1)];
            op = ($urandom_range(0, 99) < 55) ? MODE_SET : MODE_GET;
            send_request(op, key, $urandom);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_req     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        settings_run = 1;
        quiet_in     = 1'b0;
        quiet_out    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: empty miss, extreme keys and values, overwrite, fill and evict
        send_request(MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(MODE_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'h8000_0000, 32'h5555_5555);
        send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(MODE_SET, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(MODE_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send_request(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        for (int k = 1; k <= 12; k++) send_request(MODE_SET, 32'(k), 32'(k * 1000));
        send_request(MODE_SET, 32'd100, 32'hDEAD_BEEF);
        send_request(MODE_SET, 32'd101, 32'hCAFE_F00D);
        send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);

        // Random phases over several capacities, extremes among them
        run_random(170, 22);
        write_capacity(0);
        run_random(60, 8);
        write_capacity(1);
        run_random(150, 4);
        write_capacity(31);
        run_random(170, 24);
        write_capacity(2);
        run_random(150, 6);
        write_capacity(17);
        run_random(120, 22);
        write_capacity(5);
        run_random(150, 10);
        write_capacity(8);
        run_random(140, 14);
        write_capacity(16);
        run_random(90, 20);

        settle();
        repeat (40) @(posedge i_clk);
        $display("Checked %0d requests across %0d capacity settings", responses, settings_run);
        $display("Saw %0d hits and %0d evictions", hit_total, evict_total);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
